// ===== src/solution_upsample_index_map_defines.svh =====
// assertion macros shared by the checker
`ifndef SOLUTION_UPSAMPLE_INDEX_MAP_DEFINES_SVH
`define SOLUTION_UPSAMPLE_INDEX_MAP_DEFINES_SVH

// property checked outside reset
`define UPIM_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("upim assertion failed");

// property checked on every edge, reset included
`define UPIM_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("upim assertion failed");

`endif

// ===== src/upim_pkg.sv =====
package upim_pkg;

  localparam int MAX_DIR_DEF = 8;
  localparam int CNT_W       = 10;
  localparam int TIME_W      = 32;
  localparam int OFF_W       = 25;
  localparam int SUM_W       = 14;
  localparam int DIV_WIDE    = 32;
  localparam int DIV_NARROW  = 10;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_MAP   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    REG_SI     = 2'd0,
    REG_POL    = 2'd1,
    REG_DIRTOT = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    DS_SI_C,
    DS_MAX_C,
    DS_T,
    DS_SUB_C,
    DS_REM_Q
  } div_sel_t;

  typedef struct packed {
    logic     capture;
    logic     wr_table;
    logic     walk_acc;
    logic     idx_clr;
    logic     idx_inc;
    logic     div_start;
    div_sel_t div_sel;
    logic     chk_si;
    logic     chk_max;
    logic     st_t;
    logic     st_q2;
    logic     st_sub;
    logic     mul1;
    logic     mul2;
    logic     mul3;
    logic     load_out;
    status_t  out_status;
  } cmd_t;

  typedef struct packed {
    logic is_write;
    logic out_of_range;
    logic idx_last;
    logic div_busy;
    logic bad;
    logic out_full;
  } sts_t;

endpackage

// ===== src/upim_div.sv =====
module upim_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        wide,
  input  logic [31:0] dividend,
  input  logic [9:0]  divisor,
  output logic        busy,
  output logic [31:0] quotient,
  output logic [9:0]  remainder
);
  import upim_pkg::*;

  logic [31:0] q_r, q_nxt;
  logic [9:0]  r_r, r_nxt;
  logic [9:0]  d_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [10:0] trial;
  logic [10:0] diff;

  always_comb begin
    trial = {r_r, q_r[31]};
    diff  = trial - {1'b0, d_r};
    if (trial >= {1'b0, d_r}) begin
      r_nxt = diff[9:0];
      q_nxt = {q_r[30:0], 1'b1};
    end else begin
      r_nxt = trial[9:0];
      q_nxt = {q_r[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= wide ? 6'(DIV_WIDE) : 6'(DIV_NARROW);
      d_r    <= divisor;
      r_r    <= '0;
      q_r    <= wide ? dividend : {dividend[9:0], 22'd0};
    end else if (busy_r) begin
      q_r   <= q_nxt;
      r_r   <= r_nxt;
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy      = busy_r;
  assign quotient  = q_r;
  assign remainder = r_r;

endmodule

// ===== src/upim_dp.sv =====
module upim_dp #(
  parameter int MAX_DIRECTIONS = upim_pkg::MAX_DIR_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  upim_pkg::cmd_t cmd,
  output upim_pkg::sts_t sts,
  input  logic [9:0]     cfg_si,
  input  logic [2:0]     cfg_pol,
  input  logic [3:0]     cfg_dirtot,
  input  logic           in_operation,
  input  logic [2:0]     in_direction,
  input  logic [9:0]     in_solution_count,
  input  logic [31:0]    in_time_step,
  input  logic [9:0]     in_antenna,
  input  logic [1:0]     in_polarization,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_original_time,
  output logic [24:0]    out_source_offset,
  output logic [1:0]     out_status
);
  import upim_pkg::*;

  localparam int IW = (MAX_DIRECTIONS > 1) ? $clog2(MAX_DIRECTIONS) : 1;

  logic [CNT_W-1:0] tbl_r [MAX_DIRECTIONS];

  logic              op_r;
  logic [2:0]        dir_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [TIME_W-1:0] t_r;
  logic [9:0]        ant_r;
  logic [1:0]        pol_r;

  logic [3:0]        idx_r;
  logic [CNT_W-1:0]  maxc_r, cdir_r, remt_r, q2_r, sub_r;
  logic [SUM_W-1:0]  sum_r, prefix_r;
  logic              bad_r, use_si_r;
  logic [TIME_W-1:0] orig_r;
  logic [OFF_W-1:0]  prod_r, off_r;

  logic              ov_r;
  logic [TIME_W-1:0] ot_r;
  logic [OFF_W-1:0]  oo_r;
  logic [1:0]        os_r;

  logic [3:0]        total;
  logic [CNT_W-1:0]  c_rd, substeps;
  logic [31:0]       dvd;
  logic [9:0]        dvs;
  logic              dwide, dbusy;
  logic [31:0]       dq;
  logic [9:0]        dr;
  logic [23:0]       p1;
  logic [27:0]       p2;
  logic [14:0]       ps;
  logic [17:0]       p3;

  always_comb begin
    if (int'(cfg_dirtot) > MAX_DIRECTIONS) begin
      total = 4'(MAX_DIRECTIONS);
    end else begin
      total = cfg_dirtot;
    end
  end

  assign c_rd     = tbl_r[IW'(idx_r)];
  assign substeps = use_si_r ? cfg_si : maxc_r;

  always_comb begin
    dwide = 1'b0;
    unique case (cmd.div_sel)
      DS_SI_C: begin
        dvd = {22'd0, cfg_si};
        dvs = c_rd;
      end
      DS_MAX_C: begin
        dvd = {22'd0, maxc_r};
        dvs = c_rd;
      end
      DS_T: begin
        dvd   = t_r;
        dvs   = substeps;
        dwide = 1'b1;
      end
      DS_SUB_C: begin
        dvd = {22'd0, substeps};
        dvs = cdir_r;
      end
      DS_REM_Q: begin
        dvd = {22'd0, remt_r};
        dvs = q2_r;
      end
      default: begin
        dvd = '0;
        dvs = '0;
      end
    endcase
  end

  upim_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .wide      (dwide),
    .dividend  (dvd),
    .divisor   (dvs),
    .busy      (dbusy),
    .quotient  (dq),
    .remainder (dr)
  );

  assign p1 = ant_r * sum_r;
  assign p2 = prod_r * cfg_pol;
  assign ps = {1'b0, prefix_r} + {5'd0, sub_r};
  assign p3 = ps * cfg_pol;

  // direction count table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_DIRECTIONS; k++) begin
        tbl_r[k] <= CNT_W'(1);
      end
    end else if (cmd.wr_table && (int'(dir_r) < MAX_DIRECTIONS)) begin
      tbl_r[IW'(dir_r)] <= cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r     <= in_operation;
      dir_r    <= in_direction;
      cnt_r    <= in_solution_count;
      t_r      <= in_time_step;
      ant_r    <= in_antenna;
      pol_r    <= in_polarization;
      idx_r    <= '0;
      maxc_r   <= '0;
      sum_r    <= '0;
      prefix_r <= '0;
      cdir_r   <= '0;
      bad_r    <= 1'b0;
      use_si_r <= 1'b0;
    end else begin
      if (cmd.walk_acc) begin
        if (c_rd == '0 || cfg_si == '0) begin
          bad_r <= 1'b1;
        end
        if (c_rd > maxc_r) begin
          maxc_r <= c_rd;
        end
        sum_r <= sum_r + {4'd0, c_rd};
        if (idx_r < {1'b0, dir_r}) begin
          prefix_r <= prefix_r + {4'd0, c_rd};
        end
        if (idx_r == {1'b0, dir_r}) begin
          cdir_r <= c_rd;
        end
      end
      if (cmd.chk_si && dr != '0) begin
        bad_r <= 1'b1;
      end
      if (cmd.chk_max && dr != '0) begin
        use_si_r <= 1'b1;
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 4'd1;
      end
    end
    if (cmd.st_t) begin
      orig_r <= dq;
      remt_r <= dr;
    end
    if (cmd.st_q2) begin
      q2_r <= dq[9:0];
    end
    if (cmd.st_sub) begin
      sub_r <= dq[9:0];
    end
    if (cmd.mul1) begin
      prod_r <= {1'b0, p1};
    end
    if (cmd.mul2) begin
      prod_r <= p2[OFF_W-1:0];
    end
    if (cmd.mul3) begin
      off_r <= prod_r + {7'd0, p3} + {23'd0, pol_r};
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.load_out) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      os_r <= cmd.out_status;
      if (cmd.out_status == ST_OK) begin
        ot_r <= orig_r;
        oo_r <= off_r;
      end else begin
        ot_r <= '0;
        oo_r <= '0;
      end
    end
  end

  assign out_valid         = ov_r;
  assign out_original_time = ot_r;
  assign out_source_offset = oo_r;
  assign out_status        = os_r;

  assign sts.is_write     = (op_r == OP_WRITE);
  assign sts.out_of_range = ({1'b0, dir_r} >= total);
  assign sts.idx_last     = (idx_r == total - 4'd1);
  assign sts.div_busy     = dbusy;
  assign sts.bad          = bad_r;
  assign sts.out_full     = ov_r && !out_ready;

endmodule

// ===== src/upim_ctrl.sv =====
module upim_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  upim_pkg::sts_t sts,
  output upim_pkg::cmd_t cmd
);
  import upim_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_CHK1,
    S_GATE,
    S_PASS2,
    S_CHK2,
    S_TDIV,
    S_TWAIT,
    S_SDIV,
    S_SWAIT,
    S_UDIV,
    S_UWAIT,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_RESULT
  } state_t;

  state_t  state_r, state_nxt;
  status_t res_st_r, res_st_nxt;

  always_comb begin
    state_nxt      = state_r;
    res_st_nxt     = res_st_r;
    cmd            = '0;
    cmd.out_status = res_st_r;
    in_ready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_write) begin
          cmd.wr_table = 1'b1;
          state_nxt    = S_IDLE;
        end else if (sts.out_of_range) begin
          res_st_nxt = ST_RANGE;
          state_nxt  = S_RESULT;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        cmd.walk_acc  = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_SI_C;
        state_nxt     = S_CHK1;
      end
      S_CHK1: begin
        if (!sts.div_busy) begin
          cmd.chk_si = 1'b1;
          if (sts.idx_last) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_GATE;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_WALK;
          end
        end
      end
      S_GATE: begin
        if (sts.bad) begin
          res_st_nxt = ST_BAD;
          state_nxt  = S_RESULT;
        end else begin
          state_nxt = S_PASS2;
        end
      end
      S_PASS2: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_MAX_C;
        state_nxt     = S_CHK2;
      end
      S_CHK2: begin
        if (!sts.div_busy) begin
          cmd.chk_max = 1'b1;
          if (sts.idx_last) begin
            state_nxt = S_TDIV;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_PASS2;
          end
        end
      end
      S_TDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_T;
        state_nxt     = S_TWAIT;
      end
      S_TWAIT: begin
        if (!sts.div_busy) begin
          cmd.st_t  = 1'b1;
          state_nxt = S_SDIV;
        end
      end
      S_SDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_SUB_C;
        state_nxt     = S_SWAIT;
      end
      S_SWAIT: begin
        if (!sts.div_busy) begin
          cmd.st_q2 = 1'b1;
          state_nxt = S_UDIV;
        end
      end
      S_UDIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DS_REM_Q;
        state_nxt     = S_UWAIT;
      end
      S_UWAIT: begin
        if (!sts.div_busy) begin
          cmd.st_sub = 1'b1;
          state_nxt  = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_MUL3;
      end
      S_MUL3: begin
        cmd.mul3   = 1'b1;
        res_st_nxt = ST_OK;
        state_nxt  = S_RESULT;
      end
      S_RESULT: begin
        if (!sts.out_full) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      res_st_r <= ST_OK;
    end else begin
      state_r  <= state_nxt;
      res_st_r <= res_st_nxt;
    end
  end

endmodule

// ===== src/solution_upsample_index_map.sv =====
// channel   dir   handshake               payload
// in        in    in_valid / in_ready     operation direction solution_count time_step
//                                         antenna polarization
// out       out   out_valid / out_ready   original_time source_offset status
// cfg       in    apb psel/penable/pready interval_steps pol_count direction_total
//
// map items run every division through the shared one-bit-per-cycle divider
// (10 steps per table check, 32 steps for the time division); one item in
// flight at a time; the result register frees the core while a result waits;
// synchronous active-low reset, table entries reset to 1
module solution_upsample_index_map #(
  parameter int MAX_DIRECTIONS = upim_pkg::MAX_DIR_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [2:0]  in_direction,
  input  logic [9:0]  in_solution_count,
  input  logic [31:0] in_time_step,
  input  logic [9:0]  in_antenna,
  input  logic [1:0]  in_polarization,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_original_time,
  output logic [24:0] out_source_offset,
  output logic [1:0]  out_status,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import upim_pkg::*;

  cmd_t       cmd;
  sts_t       sts;
  logic [9:0] si_r;
  logic [2:0] pol_r;
  logic [3:0] dirtot_r;
  reg_idx_t   ridx;

  assign ridx       = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      si_r     <= 10'd1;
      pol_r    <= 3'd1;
      dirtot_r <= 4'd1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (ridx)
        REG_SI:     si_r     <= cfg_pwdata[9:0];
        REG_POL:    pol_r    <= cfg_pwdata[2:0];
        REG_DIRTOT: dirtot_r <= cfg_pwdata[3:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_SI:     cfg_prdata = {22'd0, si_r};
      REG_POL:    cfg_prdata = {29'd0, pol_r};
      REG_DIRTOT: cfg_prdata = {28'd0, dirtot_r};
      default:    cfg_prdata = '0;
    endcase
  end

  upim_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  upim_dp #(
    .MAX_DIRECTIONS (MAX_DIRECTIONS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .cfg_si            (si_r),
    .cfg_pol           (pol_r),
    .cfg_dirtot        (dirtot_r),
    .in_operation      (in_operation),
    .in_direction      (in_direction),
    .in_solution_count (in_solution_count),
    .in_time_step      (in_time_step),
    .in_antenna        (in_antenna),
    .in_polarization   (in_polarization),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_original_time (out_original_time),
    .out_source_offset (out_source_offset),
    .out_status        (out_status)
  );

endmodule

// ===== src/upim_checker.sv =====
`include "solution_upsample_index_map_defines.svh"

module upim_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_original_time,
  input logic [24:0] out_source_offset,
  input logic [1:0]  out_status
);
  import upim_pkg::*;

  // a waiting result holds
  `UPIM_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_original_time) && $stable(out_source_offset) && $stable(out_status))

  // error results carry zero fields
  `UPIM_ASSERT(a_err_zero, clk, rst_n, out_valid && out_status != ST_OK |-> out_original_time == '0 && out_source_offset == '0)

  // one transaction in flight: ready drops after an accept
  `UPIM_ASSERT(a_one_inflight, clk, rst_n, in_valid && in_ready |=> !in_ready)

  // reset empties the result register
  `UPIM_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind solution_upsample_index_map upim_checker u_chk (.*);
